// ----- hdl/bpc_pkg.sv -----
// shared types, constants and helpers of the pressure compensation block
// no dependencies
`default_nettype none
package bpc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_OSS     = 3'd0;
  localparam logic [2:0] REG_AC1     = 3'd1;
  localparam logic [2:0] REG_AC2     = 3'd2;
  localparam logic [2:0] REG_AC3     = 3'd3;
  localparam logic [2:0] REG_AC4     = 3'd4;
  localparam logic [2:0] REG_AC5_AC6 = 3'd5;
  localparam logic [2:0] REG_B1_B2   = 3'd6;
  localparam logic [2:0] REG_MC_MD   = 3'd7;

  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DIV_STEPS = 32;

  // compensation constants, 32-bit two's complement
  localparam logic [31:0] C_B6_OFS  = 32'd4000;
  localparam logic [31:0] C_P_SQ    = 32'd3038;
  localparam logic [31:0] C_P_LIN   = 32'hFFFF_E343; // -7357
  localparam logic [31:0] C_P_OFS   = 32'd3791;
  localparam logic [31:0] C_B7_BASE = 32'd50000;
  localparam logic [31:0] C_X3_OFS  = 32'd32768;

  // sideband carried alongside a divide
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] up;
    logic        neg;
    logic        err;
    logic        dbl;
  } bpc_side_t;

  // arithmetic shift right of a 32-bit word
  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // sign extension of a 16-bit field
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bpc_if.sv -----
// valid/ready channels for sample words and result words
// no dependencies
`default_nettype none
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_tenths;
  logic [19:0]        pressure_pa;
  logic               divide_error;
  modport source (output valid, temperature_tenths, pressure_pa, divide_error,
                  input ready);
  modport sink (input valid, temperature_tenths, pressure_pa, divide_error,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/bpc_div.sv -----
// pipelined unsigned 32-bit divider, one restoring step per stage
// depends on bpc_pkg
`default_nettype none
module bpc_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [31:0]        dividend,
  input  wire logic [31:0]        divisor,
  input  wire bpc_pkg::bpc_side_t side,
  output logic                    out_valid,
  output logic [31:0]             quotient,
  output bpc_pkg::bpc_side_t      out_side
);
  import bpc_pkg::*;

  logic [31:0] acc [0:DIV_STEPS];
  logic [31:0] rem [0:DIV_STEPS];
  logic [31:0] dvs [0:DIV_STEPS];
  bpc_side_t   sb  [0:DIV_STEPS];
  logic        vld [0:DIV_STEPS];

  logic [31:0] acc_next [0:DIV_STEPS-1];
  logic [31:0] rem_next [0:DIV_STEPS-1];

  // one quotient bit per stage
  always_comb begin
    logic [32:0] sh;
    logic [32:0] df;
    for (int k = 0; k < DIV_STEPS; k++) begin
      sh = {rem[k], acc[k][31]};
      df = sh - {1'b0, dvs[k]};
      if (!df[32]) begin
        rem_next[k] = df[31:0];
        acc_next[k] = {acc[k][30:0], 1'b1};
      end else begin
        rem_next[k] = sh[31:0];
        acc_next[k] = {acc[k][30:0], 1'b0};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= dividend;
      rem[0] <= '0;
      dvs[0] <= divisor;
      sb[0]  <= side;
      for (int k = 0; k < DIV_STEPS; k++) begin
        acc[k+1] <= acc_next[k];
        rem[k+1] <= rem_next[k];
        dvs[k+1] <= dvs[k];
        sb[k+1]  <= sb[k];
      end
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 0; k < DIV_STEPS; k++) vld[k+1] <= vld[k];
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign quotient  = acc[DIV_STEPS];
  assign out_side  = sb[DIV_STEPS];

  // a stalled divider holds its last stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(acc[DIV_STEPS]) && $stable(vld[DIV_STEPS]))
    else $error("divider moved while stalled");
  // reset empties the line
  a_rst: assert property (@(posedge clk) $past(rst) |-> !vld[DIV_STEPS])
    else $error("divider valid after reset");
  // the last stage's remainder stays below its divisor while its word is valid
  a_rem: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STEPS] && dvs[DIV_STEPS] != 0 |-> rem[DIV_STEPS] < dvs[DIV_STEPS])
    else $error("divider remainder out of range");
endmodule
`default_nettype wire

// ----- hdl/barometric_pressure_compensation_unit.sv -----
// top level: register file and compensation pipeline with two dividers
// depends on bpc_pkg, bpc_if, bpc_div
//
//  channel  dir  handshake          payload
//  sample   in   valid/ready        raw_temperature, raw_pressure
//  result   out  valid/ready        temperature_tenths, pressure_pa, divide_error
//  apb      in   psel/penable       paddr, pwdata -> prdata, pready always high
//
// one word per cycle while the pipeline advances; the latency is set by the two
// 32-stage dividers and the multiply stages around them
// rst is synchronous and clears all valid bits and the configuration registers
// the whole pipeline advances while the result register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated
`default_nettype none
module barometric_pressure_compensation_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  bpc_in_if.sink                          sample,
  bpc_out_if.source                       result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import bpc_pkg::*;

  // configuration registers
  logic [1:0]  oss;
  logic [15:0] ac1, ac2, ac3, ac4;
  logic [31:0] ac5_ac6, b1_b2, mc_md;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      oss <= '0; ac1 <= '0; ac2 <= '0; ac3 <= '0; ac4 <= '0;
      ac5_ac6 <= '0; b1_b2 <= '0; mc_md <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_OSS:     oss <= pwdata[1:0];
        REG_AC1:     ac1 <= pwdata[15:0];
        REG_AC2:     ac2 <= pwdata[15:0];
        REG_AC3:     ac3 <= pwdata[15:0];
        REG_AC4:     ac4 <= pwdata[15:0];
        REG_AC5_AC6: ac5_ac6 <= pwdata;
        REG_B1_B2:   b1_b2 <= pwdata;
        REG_MC_MD:   mc_md <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[4:2])
      REG_OSS:     prdata = {30'd0, oss};
      REG_AC1:     prdata = {16'd0, ac1};
      REG_AC2:     prdata = {16'd0, ac2};
      REG_AC3:     prdata = {16'd0, ac3};
      REG_AC4:     prdata = {16'd0, ac4};
      REG_AC5_AC6: prdata = ac5_ac6;
      REG_B1_B2:   prdata = b1_b2;
      REG_MC_MD:   prdata = mc_md;
      default:     prdata = '0;
    endcase
  end

  // coefficient views
  logic [31:0] k_ac1, k_ac2, k_ac3, k_ac4, k_ac5, k_ac6, k_b1, k_b2, k_mc, k_md;
  assign k_ac1 = sx16(ac1);
  assign k_ac2 = sx16(ac2);
  assign k_ac3 = sx16(ac3);
  assign k_ac4 = {16'd0, ac4};
  assign k_ac5 = {16'd0, ac5_ac6[31:16]};
  assign k_ac6 = {16'd0, ac5_ac6[15:0]};
  assign k_b1  = sx16(b1_b2[31:16]);
  assign k_b2  = sx16(b1_b2[15:0]);
  assign k_mc  = sx16(mc_md[31:16]);
  assign k_md  = sx16(mc_md[15:0]);

  // global advance
  logic en;
  logic ovalid;
  assign en = !ovalid || result.ready;
  assign sample.ready = en;

  // stage a: capture, stage b: ut - ac6, stage c: times ac5
  logic        va, vb, vc;
  logic [31:0] a_ut, a_up, b_td, b_up, c_pr, c_up;
  always_ff @(posedge clk) begin
    if (en) begin
      a_ut <= {16'd0, sample.raw_temperature};
      a_up <= {8'd0, sample.raw_pressure} >> (4'd8 - {2'd0, oss});
      b_td <= a_ut - k_ac6;
      b_up <= a_up;
      c_pr <= b_td * k_ac5;
      c_up <= b_up;
    end
  end

  // divider a input: (mc << 11) / (x1 + md), signed through magnitudes
  logic [31:0] d_x1, d_dv, d_num, d_ma, d_mb;
  bpc_side_t   d_side;
  always_comb begin
    d_x1  = asr(c_pr, 5'd15);
    d_dv  = d_x1 + k_md;
    d_num = k_mc << 11;
    d_ma  = d_num[31] ? 32'd0 - d_num : d_num;
    d_mb  = d_dv[31] ? 32'd0 - d_dv : d_dv;
    d_side.x   = d_x1;
    d_side.up  = c_up;
    d_side.neg = d_num[31] ^ d_dv[31];
    d_side.err = (d_dv == 32'd0);
    d_side.dbl = 1'b0;
  end

  logic        qa_v;
  logic [31:0] qa;
  bpc_side_t   qa_side;
  bpc_div u_div_t (
    .clk(clk), .rst(rst), .en(en), .in_valid(vc),
    .dividend(d_ma), .divisor(d_mb), .side(d_side),
    .out_valid(qa_v), .quotient(qa), .out_side(qa_side)
  );

  // stage e: b5 and b6
  logic        ve;
  logic [31:0] e_b5, e_b6, e_up;
  logic        e_err;
  always_comb begin
    logic [31:0] x2;
    x2 = qa_side.neg ? 32'd0 - qa : qa;
    e_b5 = qa_side.x + x2;
  end
  logic [31:0] e_b5r;
  always_ff @(posedge clk) begin
    if (en) begin
      e_b5r <= e_b5;
      e_b6  <= e_b5 - C_B6_OFS;
      e_up  <= qa_side.up;
      e_err <= qa_side.err;
    end
  end

  // stage f: products of b6
  logic        vf;
  logic [31:0] f_bb, f_a2, f_a3, f_b5, f_up;
  logic        f_err;
  always_ff @(posedge clk) begin
    if (en) begin
      f_bb <= e_b6 * e_b6;
      f_a2 <= k_ac2 * e_b6;
      f_a3 <= k_ac3 * e_b6;
      f_b5 <= e_b5r; f_up <= e_up; f_err <= e_err;
    end
  end

  // stage g: scaled terms
  logic        vg;
  logic [31:0] g_sq, g_x2, g_x1, g_b5, g_up;
  logic        g_err;
  always_ff @(posedge clk) begin
    if (en) begin
      g_sq <= asr(f_bb, 5'd12);
      g_x2 <= asr(f_a2, 5'd11);
      g_x1 <= asr(f_a3, 5'd13);
      g_b5 <= f_b5; g_up <= f_up; g_err <= f_err;
    end
  end

  // stage h: products of sq
  logic        vh;
  logic [31:0] h_b2, h_b1, h_x2, h_x1, h_b5, h_up;
  logic        h_err;
  always_ff @(posedge clk) begin
    if (en) begin
      h_b2 <= k_b2 * g_sq;
      h_b1 <= k_b1 * g_sq;
      h_x2 <= g_x2; h_x1 <= g_x1;
      h_b5 <= g_b5; h_up <= g_up; h_err <= g_err;
    end
  end

  // stage i: b3 numerator and b4 operand
  logic        vi;
  logic [31:0] i_v, i_k, i_b5, i_up;
  logic        i_err;
  always_comb begin
    logic [31:0] x3, x3p;
    x3  = asr(h_b2, 5'd11) + h_x2;
    i_v = ((k_ac1 * 32'd4 + x3) << oss) + 32'd2;
    x3p = asr(h_x1 + asr(h_b1, 5'd16) + 32'd2, 5'd2);
    i_k = x3p + C_X3_OFS;
  end
  logic [31:0] i_vr, i_kr;
  always_ff @(posedge clk) begin
    if (en) begin
      i_vr <= i_v; i_kr <= i_k;
      i_b5 <= h_b5; i_up <= h_up; i_err <= h_err;
    end
  end

  // stage j: b3 as truncating divide by four
  logic        vj;
  logic [31:0] j_b3, j_k, j_b5, j_up;
  logic        j_err;
  always_comb begin
    logic [31:0] mag, q;
    mag = i_vr[31] ? 32'd0 - i_vr : i_vr;
    q = mag >> 2;
    j_b3 = i_vr[31] ? 32'd0 - q : q;
  end
  logic [31:0] j_b3r;
  always_ff @(posedge clk) begin
    if (en) begin
      j_b3r <= j_b3; j_k <= i_kr;
      j_b5 <= i_b5; j_up <= i_up; j_err <= i_err;
    end
  end

  // stage k: b4 product and b7
  logic        vk;
  logic [31:0] k_m4, k_b7, k_b5;
  logic        k_err;
  always_ff @(posedge clk) begin
    if (en) begin
      k_m4 <= k_ac4 * j_k;
      k_b7 <= (j_up - j_b3r) * (C_B7_BASE >> oss);
      k_b5 <= j_b5; k_err <= j_err;
    end
  end

  // divider b input
  logic [31:0] l_b4, l_dd;
  bpc_side_t   l_side;
  always_comb begin
    l_b4 = k_m4 >> 15;
    l_dd = k_b7[31] ? k_b7 : k_b7 << 1;
    l_side.x   = k_b5;
    l_side.up  = '0;
    l_side.neg = 1'b0;
    l_side.err = k_err || (l_b4 == 32'd0);
    l_side.dbl = k_b7[31];
  end

  logic        qb_v;
  logic [31:0] qb;
  bpc_side_t   qb_side;
  bpc_div u_div_p (
    .clk(clk), .rst(rst), .en(en), .in_valid(vk),
    .dividend(l_dd), .divisor(l_b4), .side(l_side),
    .out_valid(qb_v), .quotient(qb), .out_side(qb_side)
  );

  // stage m: raw pressure
  logic        vm;
  logic [31:0] m_p, m_b5;
  logic        m_err;
  always_ff @(posedge clk) begin
    if (en) begin
      m_p   <= qb_side.dbl ? qb << 1 : qb;
      m_b5  <= qb_side.x;
      m_err <= qb_side.err;
    end
  end

  // stage n: square and linear terms
  logic        vn;
  logic [31:0] n_pp, n_lin, n_p, n_b5;
  logic        n_err;
  always_ff @(posedge clk) begin
    if (en) begin
      n_pp  <= asr(m_p, 5'd8) * asr(m_p, 5'd8);
      n_lin <= C_P_LIN * m_p;
      n_p <= m_p; n_b5 <= m_b5; n_err <= m_err;
    end
  end

  // stage o: square term scaling
  logic        vo;
  logic [31:0] o_sq, o_x2, o_p, o_b5;
  logic        o_err;
  always_ff @(posedge clk) begin
    if (en) begin
      o_sq <= n_pp * C_P_SQ;
      o_x2 <= asr(n_lin, 5'd16);
      o_p <= n_p; o_b5 <= n_b5; o_err <= n_err;
    end
  end

  // stage p: corrected pressure and temperature
  logic        vp;
  logic [31:0] p_p, p_t;
  logic        p_err;
  always_ff @(posedge clk) begin
    if (en) begin
      p_p   <= o_p + asr(asr(o_sq, 5'd16) + o_x2 + C_P_OFS, 5'd4);
      p_t   <= asr(o_b5 + 32'd8, 5'd4);
      p_err <= o_err;
    end
  end

  // output register with saturation
  logic signed [15:0] r_t;
  logic [19:0]        r_p;
  logic               r_err;
  always_ff @(posedge clk) begin
    if (en) begin
      r_err <= p_err;
      if (p_err) begin
        r_t <= '0;
        r_p <= '0;
      end else begin
        if ($signed(p_t) < -32'sd32768) r_t <= 16'sh8000;
        else if ($signed(p_t) > 32'sd32767) r_t <= 16'sh7FFF;
        else r_t <= p_t[15:0];
        if (p_p[31]) r_p <= '0;
        else if (p_p > 32'h000F_FFFF) r_p <= 20'hF_FFFF;
        else r_p <= p_p[19:0];
      end
    end
  end

  // valid bits of the plain stages
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; ve <= 1'b0; vf <= 1'b0;
      vg <= 1'b0; vh <= 1'b0; vi <= 1'b0; vj <= 1'b0; vk <= 1'b0;
      vm <= 1'b0; vn <= 1'b0; vo <= 1'b0; vp <= 1'b0; ovalid <= 1'b0;
    end else if (en) begin
      va <= sample.valid; vb <= va; vc <= vb;
      ve <= qa_v; vf <= ve; vg <= vf; vh <= vg; vi <= vh; vj <= vi; vk <= vj;
      vm <= qb_v; vn <= vm; vo <= vn; vp <= vo; ovalid <= vp;
    end
  end

  assign result.valid              = ovalid;
  assign result.temperature_tenths = r_t;
  assign result.pressure_pa        = r_p;
  assign result.divide_error       = r_err;

  // an error word carries zero results
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    ovalid && r_err |-> r_t == 16'sd0 && r_p == 20'd0)
    else $error("error word with nonzero results");
  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !ovalid)
    else $error("result valid after reset");
  // a word leaving the last stage lands in the output register
  a_land: assert property (@(posedge clk) disable iff (rst)
    vp && en |=> ovalid)
    else $error("word dropped at output register");
endmodule
`default_nettype wire
